// ===== hdl/lms_pkg.sv =====
// Package for the LMS online regression trainer.
// Holds the op, result kind and register index codes, the sequencer states and saturation.
// No dependencies.
package lms_pkg;

  localparam logic [1:0] OP_FEATURE = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_WEIGHT = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [1:0] REG_COST_TOL   = 2'd1;
  localparam logic [1:0] REG_MAX_PASSES = 2'd2;

  localparam logic [47:0] COST_MAX = {48{1'b1}};

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DOT_MUL,
    ST_DOT_ACC,
    ST_PRED,
    ST_ERR,
    ST_STEP_MUL,
    ST_STEP,
    ST_SQ_MUL,
    ST_COST,
    ST_UPD_RD,
    ST_UPD_MUL,
    ST_UPD_WR,
    ST_BIAS,
    ST_PASS,
    ST_READ,
    ST_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== hdl/lms_online_regression_trainer_top.sv =====
// Top level of the LMS online regression trainer: sequencer, shared multiplier,
// weight and sample memories and the output register. Depends on lms_pkg.
//
// One item is taken at a time. A feature item that does not end a sample passes acceptance
// with the weight read, the shared multiply and the accumulate. The item that ends a sample
// adds prediction, error and the load of the output register, then, while training runs,
// the step and squared error and, per received feature, a read, multiply and write for the
// weight update, all through the one 33 x 33 bit multiplier and the single-port weight
// memory, plus bias and end-of-pass steps. A weight readout passes a read state; a readout
// at or beyond the bias index and a clear do not. The result sits in an output register, so
// the block goes on with the next item while a result waits, unless a second result is ready.
module lms_online_regression_trainer_top import lms_pkg::*; #(
  parameter int FEATURE_COUNT = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // feature[15:0], target[31:16], weight_index[35:32], zeros
  input  logic [2:0]   s_tuser,   // op[1:0], pass_last[2]
  input  logic         s_tlast,   // feature_last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // prediction, error, weight_value, converged,
                                  // training_done, passes_done[113:98], zeros
  output logic [1:0]   m_tuser    // result_kind
);

  localparam int IDXW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int PW   = $clog2(FEATURE_COUNT + 1);

  state_t state, state_next;

  logic [15:0] learn_rate;
  logic [31:0] cost_tolerance;
  logic [15:0] max_passes;

  logic [1:0]  op;
  logic signed [15:0] x_in;
  logic signed [15:0] target;
  logic        last_in, pass_last;

  logic [PW-1:0] pos, upd_i;
  logic signed [47:0] acc;
  logic signed [31:0] bias, pred, err, wv;
  logic signed [32:0] step;
  logic [47:0] pass_cost, prev_cost;
  logic [15:0] pass_count;
  logic        is_conv, is_done;
  logic [1:0]  kind;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic signed [31:0] wmem [FEATURE_COUNT];
  logic signed [15:0] smem [FEATURE_COUNT];
  logic [FEATURE_COUNT-1:0] wvalid;
  logic signed [31:0] w_rd;
  logic signed [15:0] x_rd;
  logic        wvld_rd;
  logic [IDXW-1:0] mem_addr;
  logic        w_we, s_we;
  logic signed [31:0] w_new, w_eff;

  logic in_fire, pos_room;
  assign in_fire  = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign pos_room = (pos < PW'(FEATURE_COUNT));
  assign w_eff    = wvld_rd ? w_rd : 32'sd0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate     <= 16'd655;
      cost_tolerance <= 32'd66;
      max_passes     <= 16'd1000;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_LEARN_RATE: learn_rate     <= cfg_wdata[15:0];
        REG_COST_TOL:   cost_tolerance <= cfg_wdata;
        REG_MAX_PASSES: max_passes     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_tuser[1:0])
            OP_FEATURE: state_next = pos_room ? ST_DOT_MUL : (s_tlast ? ST_PRED : ST_IDLE);
            OP_READ:    state_next = (32'(s_tdata[35:32]) < FEATURE_COUNT) ? ST_READ : ST_OUT;
            OP_CLEAR:   state_next = ST_OUT;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_DOT_MUL:  state_next = ST_DOT_ACC;
      ST_DOT_ACC:  state_next = last_in ? ST_PRED : ST_IDLE;
      ST_PRED:     state_next = ST_ERR;
      ST_ERR:      state_next = is_done ? ST_OUT : ST_STEP_MUL;
      ST_STEP_MUL: state_next = ST_STEP;
      ST_STEP:     state_next = ST_SQ_MUL;
      ST_SQ_MUL:   state_next = ST_COST;
      ST_COST:     state_next = (pos == '0) ? ST_BIAS : ST_UPD_RD;
      ST_UPD_RD:   state_next = ST_UPD_MUL;
      ST_UPD_MUL:  state_next = ST_UPD_WR;
      ST_UPD_WR:   state_next = (upd_i + PW'(1) == pos) ? ST_BIAS : ST_UPD_RD;
      ST_BIAS:     state_next = pass_last ? ST_PASS : ST_OUT;
      ST_PASS:     state_next = ST_OUT;
      ST_READ:     state_next = ST_OUT;
      ST_OUT:      state_next = (!m_tvalid || m_tready) ? ST_IDLE : ST_OUT;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Memory controls and multiplier operands.
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    w_we     = 1'b0;
    s_we     = 1'b0;
    mem_addr = upd_i[IDXW-1:0];
    w_new    = sat32(64'(w_eff) + 64'($signed(prod[47:12])));
    case (state)
      ST_IDLE: begin
        mem_addr = (s_tuser[1:0] == OP_READ) ? IDXW'(s_tdata[35:32]) : pos[IDXW-1:0];
        s_we     = in_fire && (s_tuser[1:0] == OP_FEATURE) && pos_room;
      end
      ST_DOT_MUL: begin
        mul_a = 33'(x_in);
        mul_b = 33'(w_eff);
      end
      ST_STEP_MUL: begin
        mul_a = $signed({17'd0, learn_rate});
        mul_b = 33'(err);
      end
      ST_SQ_MUL: begin
        mul_a = 33'(err);
        mul_b = 33'(err);
      end
      ST_UPD_MUL: begin
        mul_a = step;
        mul_b = 33'(x_rd);
      end
      ST_UPD_WR: w_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Weight and sample memories with registered reads.
  always_ff @(posedge clk) begin
    if (w_we) wmem[upd_i[IDXW-1:0]] <= w_new;
    w_rd <= wmem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[pos[IDXW-1:0]] <= $signed(s_tdata[15:0]);
    x_rd <= smem[mem_addr];
  end

  // Datapath and model state.
  always_ff @(posedge clk) begin
    logic signed [63:0] t;
    logic [48:0] csum;
    logic [47:0] half, diff;
    logic [15:0] pc;
    if (rst) begin
      state      <= ST_IDLE;
      wvalid     <= '0;
      pos        <= '0;
      acc        <= '0;
      bias       <= '0;
      pass_cost  <= '0;
      prev_cost  <= '0;
      pass_count <= '0;
      is_conv    <= 1'b0;
      is_done    <= 1'b0;
      wvld_rd    <= 1'b0;
      upd_i      <= '0;
    end else begin
      state   <= state_next;
      wvld_rd <= wvalid[mem_addr];
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            op        <= s_tuser[1:0];
            pass_last <= s_tuser[2];
            last_in   <= s_tlast;
            x_in      <= $signed(s_tdata[15:0]);
            target    <= $signed(s_tdata[31:16]);
            pred      <= '0;
            err       <= '0;
            wv        <= '0;
            kind      <= s_tuser[1:0];
            if (s_tuser[1:0] == OP_READ && 32'(s_tdata[35:32]) == FEATURE_COUNT) wv <= bias;
            if (s_tuser[1:0] == OP_CLEAR) begin
              wvalid     <= '0;
              bias       <= '0;
              pos        <= '0;
              acc        <= '0;
              pass_cost  <= '0;
              prev_cost  <= '0;
              pass_count <= '0;
              is_conv    <= 1'b0;
              is_done    <= 1'b0;
            end
          end
        end
        ST_DOT_ACC: begin
          acc <= acc + prod[59:12];
          pos <= pos + PW'(1);
        end
        ST_PRED: pred <= sat32(64'(bias) + 64'(acc));
        ST_ERR: begin
          t   = 64'(target) <<< 4;
          err <= sat32(t - 64'(pred));
          acc <= '0;
        end
        ST_STEP: step <= prod[48:16];
        ST_COST: begin
          csum      = {1'b0, pass_cost} + {1'b0, prod[63:16]};
          pass_cost <= csum[48] ? COST_MAX : csum[47:0];
          upd_i     <= '0;
        end
        ST_UPD_WR: begin
          wvalid[upd_i[IDXW-1:0]] <= 1'b1;
          upd_i <= upd_i + PW'(1);
        end
        ST_BIAS: bias <= sat32(64'(bias) + 64'(step));
        ST_PASS: begin
          half = pass_cost >> 1;
          diff = (half > prev_cost) ? half - prev_cost : prev_cost - half;
          pc   = (pass_count != 16'hffff) ? pass_count + 16'd1 : pass_count;
          pass_count <= pc;
          pass_cost  <= '0;
          if (diff <= 48'(cost_tolerance)) begin
            is_conv <= 1'b1;
            is_done <= 1'b1;
          end else begin
            prev_cost <= half;
            if (pc >= max_passes) is_done <= 1'b1;
          end
        end
        ST_READ: wv <= w_eff;
        ST_OUT: if (state_next == ST_IDLE && op == OP_FEATURE) pos <= '0;
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tuser  <= kind;
        m_tdata  <= {6'd0, pass_count, is_done, is_conv, wv, err, pred};
      end
    end
  end

  a_conv_done: assert property (@(posedge clk) disable iff (rst) is_conv |-> is_done)
    else $error("converged without training done");
  a_frozen: assert property (@(posedge clk) disable iff (rst) (state == ST_UPD_WR) |-> !is_done)
    else $error("weight update while training is frozen");
  a_pos: assert property (@(posedge clk) disable iff (rst) pos <= PW'(FEATURE_COUNT))
    else $error("sample position beyond feature count");
  a_upd: assert property (@(posedge clk) disable iff (rst) (state == ST_UPD_RD) |-> upd_i < pos)
    else $error("update index beyond received features");

endmodule
